FILE: sv/register_stack_machine_executor_macros.svh
// assertion macros for the register stack machine executor
`ifndef REGISTER_STACK_MACHINE_EXECUTOR_MACROS_SVH
`define REGISTER_STACK_MACHINE_EXECUTOR_MACROS_SVH
`ifndef SYNTH
`define RSME_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);
`define RSME_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define RSME_ASSERT_SAME(lbl, pre, post, msg)
`define RSME_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: sv/rsme_pkg.sv
// constants and codes of the register stack machine executor
package rsme_pkg;

  localparam int REG_COUNT = 16;
  localparam int MEM_WORDS = 1024;
  localparam int RIDX_W    = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int MADDR_W   = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int DEPTH_W   = $clog2(MEM_WORDS + 1);
  localparam logic [31:0] LIMIT_AT_RESET = 32'd1000;

  // register indexes of the configuration port
  localparam logic [7:0] CFG_PROGRAM_LENGTH    = 8'd0;
  localparam logic [7:0] CFG_INSTRUCTION_LIMIT = 8'd1;

  // opcodes
  localparam logic [4:0] OP_NOP  = 5'd0;
  localparam logic [4:0] OP_ADD  = 5'd1;
  localparam logic [4:0] OP_SUB  = 5'd2;
  localparam logic [4:0] OP_MUL  = 5'd3;
  localparam logic [4:0] OP_DIV  = 5'd4;
  localparam logic [4:0] OP_STORE = 5'd5;
  localparam logic [4:0] OP_LOAD = 5'd6;
  localparam logic [4:0] OP_LDI  = 5'd7;
  localparam logic [4:0] OP_PUSH = 5'd8;
  localparam logic [4:0] OP_POP  = 5'd9;
  localparam logic [4:0] OP_JMP  = 5'd10;
  localparam logic [4:0] OP_JZ   = 5'd11;
  localparam logic [4:0] OP_JNZ  = 5'd12;
  localparam logic [4:0] OP_MOV  = 5'd13;
  localparam logic [4:0] OP_JE   = 5'd14;
  localparam logic [4:0] OP_JNE  = 5'd15;
  localparam logic [4:0] OP_AND  = 5'd16;
  localparam logic [4:0] OP_OR   = 5'd17;
  localparam logic [4:0] OP_XOR  = 5'd18;
  localparam logic [4:0] OP_NOT  = 5'd19;
  localparam logic [4:0] OP_SHL  = 5'd20;
  localparam logic [4:0] OP_SHR  = 5'd21;
  localparam logic [4:0] OP_CMP  = 5'd22;
  localparam logic [4:0] OP_TEST = 5'd23;
  localparam logic [4:0] OP_B    = 5'd24;
  localparam logic [4:0] OP_BZ   = 5'd25;
  localparam logic [4:0] OP_BNZ  = 5'd26;
  localparam logic [4:0] OP_NEG  = 5'd27;
  localparam logic [4:0] OP_ABS  = 5'd28;
  localparam logic [4:0] OP_HALT = 5'd29;

  // run status codes
  localparam logic [3:0] ST_RUN     = 4'd0;
  localparam logic [3:0] ST_HALT    = 4'd1;
  localparam logic [3:0] ST_END     = 4'd2;
  localparam logic [3:0] ST_BADREG  = 4'd3;
  localparam logic [3:0] ST_BADADDR = 4'd4;
  localparam logic [3:0] ST_DIVZERO = 4'd5;
  localparam logic [3:0] ST_OVER    = 4'd6;
  localparam logic [3:0] ST_UNDER   = 4'd7;
  localparam logic [3:0] ST_UNKNOWN = 4'd8;
  localparam logic [3:0] ST_LIMIT   = 4'd9;

endpackage

FILE: sv/register_stack_machine_executor.sv
// Executor for a small register and stack machine, one instruction per request.
// Input channel (in_valid_i / in_stall_o) carries one fetched instruction; the
// output channel (out_valid_o / out_stall_i) returns next pointer, status and
// any register write, exactly one result per instruction, in order.
// Configuration writes (cfg_valid_i / cfg_ready_o) set program length (index 0)
// and instruction limit (index 1); they are always accepted.
// Each instruction is latched on acceptance, then the synchronous register
// file and data memory are read, then it executes and writes back; execute
// waits while the output register is stalled. DIV then runs the bit-serial
// divider (one quotient bit a cycle) and writes back the quotient after it.
// A new instruction is taken only once the previous one has executed.
// After reset the 1024-word data memory is cleared, one word a cycle; no
// instruction is accepted meanwhile.
// A stalled result is held in the output register; a further instruction may be
// accepted and read but does not execute until the output register is free.
// Any error stops the run until reset; later instructions only report it.
module register_stack_machine_executor
  import rsme_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  opcode_i,
  input  logic [7:0]  src_a_i,
  input  logic [7:0]  src_b_i,
  input  logic [7:0]  dest_reg_i,
  input  logic [15:0] address_i,
  input  logic signed [31:0] immediate_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] next_pointer_o,
  output logic [3:0]  status_o,
  output logic        write_valid_o,
  output logic [3:0]  written_register_o,
  output logic signed [31:0] written_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

`include "register_stack_machine_executor_macros.svh"

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_EXEC   = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_DIVFIN = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [MADDR_W-1:0] clr_cnt_q;

  // configuration
  logic [15:0] plen_q;
  logic [31:0] limit_q;

  // architectural state
  logic [15:0] ip_q;
  logic [31:0] exec_cnt_q;
  logic [3:0]  run_status_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [REG_COUNT-1:0] rf_valid_q;

  // latched instruction
  logic [4:0]  op_q;
  logic [7:0]  ra_q, rb_q, rd_q;
  logic [15:0] addr_q;
  logic [31:0] imm_q;

  // memories
  logic [31:0] rf_mem [REG_COUNT];
  logic [31:0] dm_mem [MEM_WORDS];
  logic [31:0] rf_rd_a_q, rf_rd_b_q, dm_rd_q;

  // divider
  logic [32:0] div_rem_q;
  logic [31:0] div_quo_q, div_den_q;
  logic [4:0]  div_cnt_q;
  logic        div_neg_q;

  // output register
  logic        out_valid_q;
  logic [15:0] out_np_q;
  logic [3:0]  out_st_q;
  logic        out_wr_q;
  logic [3:0]  out_wreg_q;
  logic [31:0] out_wval_q;

  logic in_accept, out_busy;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_busy    = out_valid_q && out_stall_i;
  assign cfg_ready_o = 1'b1;

  // operand decode
  logic ua, ub, ud;
  always_comb begin
    ua = 1'b0;
    ub = 1'b0;
    ud = 1'b0;
    case (op_q) inside
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR: begin
        ua = 1'b1; ub = 1'b1; ud = 1'b1;
      end
      OP_STORE, OP_LOAD, OP_LDI, OP_PUSH, OP_POP, OP_JZ, OP_JNZ, OP_BZ, OP_BNZ: begin
        ua = 1'b1;
      end
      OP_MOV, OP_JE, OP_JNE, OP_NOT, OP_CMP, OP_TEST, OP_NEG, OP_ABS: begin
        ua = 1'b1; ub = 1'b1;
      end
      default: ;
    endcase
  end

  logic [31:0] a, b, mag_a, mag_b;
  logic [15:0] ip_inc;
  logic        addr_ok, regs_ok;
  logic [DEPTH_W-1:0] push_idx, pop_idx;
  assign a = (ua && rf_valid_q[ra_q[RIDX_W-1:0]]) ? rf_rd_a_q : 32'd0;
  assign b = (ub && rf_valid_q[rb_q[RIDX_W-1:0]]) ? rf_rd_b_q : 32'd0;
  assign mag_a = a[31] ? (32'd0 - a) : a;
  assign mag_b = b[31] ? (32'd0 - b) : b;
  assign ip_inc = ip_q + 16'd1;
  assign addr_ok = ({16'd0, addr_q} < 32'(MEM_WORDS));
  assign regs_ok = !(ua && ({24'd0, ra_q} >= 32'(REG_COUNT))) &&
                   !(ub && ({24'd0, rb_q} >= 32'(REG_COUNT))) &&
                   !(ud && ({24'd0, rd_q} >= 32'(REG_COUNT)));
  assign push_idx = DEPTH_W'(MEM_WORDS - 1) - depth_q;
  assign pop_idx  = DEPTH_W'(MEM_WORDS) - depth_q;

  // execute stage
  logic [3:0]  st_n;
  logic [15:0] np_n;
  logic        wr_n, commit, dm_we_x, div_go;
  logic [7:0]  wreg_n;
  logic [31:0] wval_n;
  logic [MADDR_W-1:0] dm_waddr_x;
  logic [DEPTH_W-1:0] depth_n;
  always_comb begin
    st_n       = run_status_q;
    np_n       = ip_inc;
    wr_n       = 1'b0;
    wreg_n     = rd_q;
    wval_n     = 32'd0;
    commit     = 1'b0;
    dm_we_x    = 1'b0;
    div_go     = 1'b0;
    dm_waddr_x = addr_q[MADDR_W-1:0];
    depth_n    = depth_q;
    if (run_status_q != ST_RUN) begin
      np_n = ip_q;
    end else if (ip_q >= plen_q) begin
      st_n = ST_END;
      np_n = ip_q;
    end else if (exec_cnt_q >= limit_q) begin
      st_n = ST_LIMIT;
      np_n = ip_q;
    end else if (op_q >= 5'd30) begin
      st_n = ST_UNKNOWN;
      np_n = ip_q;
    end else if (!regs_ok) begin
      st_n = ST_BADREG;
      np_n = ip_q;
    end else begin
      commit = 1'b1;
      case (op_q)
        OP_ADD: begin wr_n = 1'b1; wval_n = a + b; end
        OP_SUB: begin wr_n = 1'b1; wval_n = a - b; end
        OP_MUL: begin wr_n = 1'b1; wval_n = a * b; end
        OP_DIV: begin
          commit = 1'b0;
          if (b == 32'd0) begin
            st_n = ST_DIVZERO;
            np_n = ip_q;
          end else begin
            div_go = 1'b1;
          end
        end
        OP_STORE: begin
          if (!addr_ok) begin
            st_n = ST_BADADDR; commit = 1'b0; np_n = ip_q;
          end else begin
            dm_we_x = 1'b1;
          end
        end
        OP_LOAD: begin
          if (!addr_ok) begin
            st_n = ST_BADADDR; commit = 1'b0; np_n = ip_q;
          end else begin
            wr_n = 1'b1; wreg_n = ra_q; wval_n = dm_rd_q;
          end
        end
        OP_LDI: begin wr_n = 1'b1; wreg_n = ra_q; wval_n = imm_q; end
        OP_PUSH: begin
          if ({{(32-DEPTH_W){1'b0}}, depth_q} >= 32'(MEM_WORDS)) begin
            st_n = ST_OVER; commit = 1'b0; np_n = ip_q;
          end else begin
            dm_we_x = 1'b1;
            dm_waddr_x = push_idx[MADDR_W-1:0];
            depth_n = depth_q + DEPTH_W'(1);
          end
        end
        OP_POP: begin
          if (depth_q == '0) begin
            st_n = ST_UNDER; commit = 1'b0; np_n = ip_q;
          end else begin
            depth_n = depth_q - DEPTH_W'(1);
            wr_n = 1'b1; wreg_n = ra_q; wval_n = dm_rd_q;
          end
        end
        OP_JMP, OP_B: np_n = addr_q;
        OP_JZ, OP_BZ: if (a == 32'd0) np_n = addr_q;
        OP_JNZ, OP_BNZ: if (a != 32'd0) np_n = addr_q;
        OP_MOV: begin wr_n = 1'b1; wreg_n = ra_q; wval_n = b; end
        OP_JE: if (a == b) np_n = addr_q;
        OP_JNE: if (a != b) np_n = addr_q;
        OP_AND: begin wr_n = 1'b1; wval_n = a & b; end
        OP_OR:  begin wr_n = 1'b1; wval_n = a | b; end
        OP_XOR: begin wr_n = 1'b1; wval_n = a ^ b; end
        OP_NOT: begin wr_n = 1'b1; wreg_n = rb_q; wval_n = ~a; end
        OP_SHL: begin wr_n = 1'b1; wval_n = a << b[4:0]; end
        OP_SHR: begin wr_n = 1'b1; wval_n = 32'($signed(a) >>> b[4:0]); end
        OP_CMP: begin
          wr_n = 1'b1; wreg_n = 8'd0;
          if (a == b) wval_n = 32'd0;
          else if ($signed(a) < $signed(b)) wval_n = 32'hFFFF_FFFF;
          else wval_n = 32'd1;
        end
        OP_TEST: begin wr_n = 1'b1; wreg_n = 8'd0; wval_n = a & b; end
        OP_NEG: begin wr_n = 1'b1; wreg_n = rb_q; wval_n = 32'd0 - a; end
        OP_ABS: begin wr_n = 1'b1; wreg_n = rb_q; wval_n = mag_a; end
        OP_HALT: begin st_n = ST_HALT; np_n = ip_q; end
        default: ;
      endcase
    end
  end

  // divider step and final sign
  logic [32:0] div_trial;
  logic [31:0] div_q_fin;
  assign div_trial = {div_rem_q[31:0], div_quo_q[31]};
  assign div_q_fin = div_neg_q ? (32'd0 - div_quo_q) : div_quo_q;

  logic exec_fire, fin_fire, out_load;
  assign exec_fire = (state_q == S_EXEC) && !out_busy;
  assign fin_fire  = (state_q == S_DIVFIN) && !out_busy;
  assign out_load  = (exec_fire && !div_go) || fin_fire;

  // register file write port
  logic              rf_we;
  logic [RIDX_W-1:0] rf_waddr;
  logic [31:0]       rf_wdata;
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = rd_q[RIDX_W-1:0];
    rf_wdata = div_q_fin;
    if (exec_fire && commit && wr_n) begin
      rf_we    = 1'b1;
      rf_waddr = wreg_n[RIDX_W-1:0];
      rf_wdata = wval_n;
    end else if (fin_fire) begin
      rf_we = 1'b1;
    end
  end

  // data memory read address
  logic [MADDR_W-1:0] dm_raddr;
  assign dm_raddr = (op_q == OP_POP) ? pop_idx[MADDR_W-1:0] : addr_q[MADDR_W-1:0];

  // register file memory
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    rf_rd_a_q <= rf_mem[ra_q[RIDX_W-1:0]];
    rf_rd_b_q <= rf_mem[rb_q[RIDX_W-1:0]];
  end

  // data memory, cleared after reset
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      dm_mem[clr_cnt_q] <= 32'd0;
    end else if (exec_fire && dm_we_x) begin
      dm_mem[dm_waddr_x] <= a;
    end
    dm_rd_q <= dm_mem[dm_raddr];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (clr_cnt_q == MADDR_W'(MEM_WORDS - 1)) state_d = S_IDLE;
      S_IDLE:   if (in_accept) state_d = S_READ;
      S_READ:   state_d = S_EXEC;
      S_EXEC:   if (exec_fire) state_d = div_go ? S_DIV : S_IDLE;
      S_DIV:    if (div_cnt_q == 5'd0) state_d = S_DIVFIN;
      S_DIVFIN: if (fin_fire) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_cnt_q    <= '0;
      plen_q       <= 16'd0;
      limit_q      <= LIMIT_AT_RESET;
      ip_q         <= 16'd0;
      exec_cnt_q   <= 32'd0;
      run_status_q <= ST_RUN;
      depth_q      <= '0;
      rf_valid_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + MADDR_W'(1);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_PROGRAM_LENGTH) plen_q <= cfg_data_i[15:0];
        else if (cfg_index_i == CFG_INSTRUCTION_LIMIT) limit_q <= cfg_data_i;
      end
      if (exec_fire) begin
        run_status_q <= st_n;
        if (commit) begin
          ip_q       <= np_n;
          exec_cnt_q <= exec_cnt_q + 32'd1;
          depth_q    <= depth_n;
        end
      end
      if (fin_fire) begin
        ip_q       <= ip_inc;
        exec_cnt_q <= exec_cnt_q + 32'd1;
      end
      if (rf_we) begin
        rf_valid_q[rf_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // instruction latch, divider and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= opcode_i;
      ra_q   <= src_a_i;
      rb_q   <= src_b_i;
      rd_q   <= dest_reg_i;
      addr_q <= address_i;
      imm_q  <= immediate_i;
    end
    if (exec_fire && div_go) begin
      div_rem_q <= 33'd0;
      div_quo_q <= mag_a;
      div_den_q <= mag_b;
      div_cnt_q <= 5'd31;
      div_neg_q <= a[31] ^ b[31];
    end else if (state_q == S_DIV) begin
      if (div_trial >= {1'b0, div_den_q}) begin
        div_rem_q <= div_trial - {1'b0, div_den_q};
        div_quo_q <= {div_quo_q[30:0], 1'b1};
      end else begin
        div_rem_q <= div_trial;
        div_quo_q <= {div_quo_q[30:0], 1'b0};
      end
      div_cnt_q <= div_cnt_q - 5'd1;
    end
    if (exec_fire && !div_go) begin
      out_np_q   <= commit ? np_n : ip_q;
      out_st_q   <= st_n;
      out_wr_q   <= commit && wr_n;
      out_wreg_q <= (commit && wr_n) ? wreg_n[3:0] : 4'd0;
      out_wval_q <= (commit && wr_n) ? wval_n : 32'd0;
    end else if (fin_fire) begin
      out_np_q   <= ip_inc;
      out_st_q   <= ST_RUN;
      out_wr_q   <= 1'b1;
      out_wreg_q <= rd_q[3:0];
      out_wval_q <= div_q_fin;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign next_pointer_o     = out_np_q;
  assign status_o           = out_st_q;
  assign write_valid_o      = out_wr_q;
  assign written_register_o = out_wreg_q;
  assign written_value_o    = out_wval_q;

  // checks
  `RSME_ASSERT_NEXT(a_stop_sticky, run_status_q != ST_RUN, run_status_q == $past(run_status_q), "run stop not sticky")
  `RSME_ASSERT_NEXT(a_count_monotone, 1'b1, exec_cnt_q >= $past(exec_cnt_q), "executed count went back")
  `RSME_ASSERT_SAME(a_result_source, $rose(out_valid_q), $past(state_q == S_EXEC || state_q == S_DIVFIN), "result without execute")

endmodule

FILE: bench/testbench.sv
// self-checking testbench for the register stack machine executor
`timescale 1ns / 100ps

module testbench;
  import rsme_pkg::*;

  typedef struct packed {
    logic [4:0]  op;
    logic [7:0]  ra;
    logic [7:0]  rb;
    logic [7:0]  rd;
    logic [15:0] addr;
    logic [31:0] imm;
  } instr_t;

  typedef struct packed {
    logic [15:0] ptr;
    logic [3:0]  status;
    logic        wr;
    logic [3:0]  wreg;
    logic [31:0] wval;
  } outcome_t;

  typedef struct packed {
    instr_t      ins;
    logic        known;
    logic [31:0] wval;
  } row_t;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ROWS = 27;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [4:0]  opcode_i = '0;
  logic [7:0]  src_a_i = '0;
  logic [7:0]  src_b_i = '0;
  logic [7:0]  dest_reg_i = '0;
  logic [15:0] address_i = '0;
  logic signed [31:0] immediate_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] next_pointer_o;
  logic [3:0]  status_o;
  logic        write_valid_o;
  logic [3:0]  written_register_o;
  logic signed [31:0] written_value_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  register_stack_machine_executor DUT (.*);

  always #5 clk_i = ~clk_i;

  // machine state as the bench sees it
  logic [31:0] regs [REG_COUNT];
  logic [31:0] dmem [MEM_WORDS];
  int unsigned sp_depth;
  logic [15:0] ip;
  logic [31:0] retired;
  logic [3:0]  run_st;
  logic [15:0] prog_len;
  logic [31:0] instr_limit;

  outcome_t pending_outcomes [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  bit quiet_in = 0;
  bit quiet_out = 0;

  // directed stimulus, typed value where it is obvious
  row_t dir_rows [0:ROWS-1] = '{
    '{'{OP_LDI, 8'd1, 8'd0, 8'd0, 16'd0, 32'h7FFFFFFF}, 1'b1, 32'h7FFFFFFF},
    '{'{OP_LDI, 8'd2, 8'd0, 8'd0, 16'd0, 32'h80000000}, 1'b1, 32'h80000000},
    '{'{OP_LDI, 8'd3, 8'd0, 8'd0, 16'd0, 32'hFFFFFFFF}, 1'b1, 32'hFFFFFFFF},
    '{'{OP_ADD, 8'd1, 8'd1, 8'd5, 16'd0, 32'd0}, 1'b1, 32'hFFFFFFFE},
    '{'{OP_SUB, 8'd2, 8'd1, 8'd6, 16'd0, 32'd0}, 1'b1, 32'h00000001},
    '{'{OP_MUL, 8'd1, 8'd3, 8'd7, 16'd0, 32'd0}, 1'b1, 32'h80000001},
    '{'{OP_DIV, 8'd2, 8'd3, 8'd8, 16'd0, 32'd0}, 1'b1, 32'h80000000},
    '{'{OP_ABS, 8'd2, 8'd9, 8'd0, 16'd0, 32'd0}, 1'b1, 32'h80000000},
    '{'{OP_NEG, 8'd2, 8'd10, 8'd0, 16'd0, 32'd0}, 1'b1, 32'h80000000},
    '{'{OP_NOT, 8'd4, 8'd11, 8'd0, 16'd0, 32'd0}, 1'b1, 32'hFFFFFFFF},
    '{'{OP_SHL, 8'd1, 8'd3, 8'd12, 16'd0, 32'd0}, 1'b1, 32'h80000000},
    '{'{OP_SHR, 8'd2, 8'd3, 8'd13, 16'd0, 32'd0}, 1'b1, 32'hFFFFFFFF},
    '{'{OP_CMP, 8'd2, 8'd1, 8'd0, 16'd0, 32'd0}, 1'b1, 32'hFFFFFFFF},
    '{'{OP_TEST, 8'd1, 8'd3, 8'd0, 16'd0, 32'd0}, 1'b1, 32'h7FFFFFFF},
    '{'{OP_STORE, 8'd1, 8'd0, 8'd0, 16'd1023, 32'd0}, 1'b0, 32'd0},
    '{'{OP_PUSH, 8'd2, 8'd0, 8'd0, 16'd0, 32'd0}, 1'b0, 32'd0},
    '{'{OP_POP, 8'd14, 8'd0, 8'd0, 16'd0, 32'd0}, 1'b1, 32'h80000000},
    '{'{OP_LOAD, 8'd15, 8'd0, 8'd0, 16'd1023, 32'd0}, 1'b1, 32'h80000000},
    '{'{OP_JZ, 8'd4, 8'd0, 8'd0, 16'd100, 32'd0}, 1'b0, 32'd0},
    '{'{OP_JNZ, 8'd4, 8'd0, 8'd0, 16'd7, 32'd0}, 1'b0, 32'd0},
    '{'{OP_JE, 8'd1, 8'd4, 8'd0, 16'd9, 32'd0}, 1'b0, 32'd0},
    '{'{OP_JNE, 8'd1, 8'd4, 8'd0, 16'd50, 32'd0}, 1'b0, 32'd0},
    '{'{OP_B, 8'd0, 8'd0, 8'd0, 16'd65533, 32'd0}, 1'b0, 32'd0},
    '{'{OP_JMP, 8'd0, 8'd0, 8'd0, 16'd0, 32'd0}, 1'b0, 32'd0},
    '{'{OP_MOV, 8'd4, 8'd1, 8'd0, 16'd0, 32'd0}, 1'b1, 32'h7FFFFFFF},
    '{'{OP_XOR, 8'd1, 8'd3, 8'd5, 16'd0, 32'd0}, 1'b1, 32'h80000000},
    '{'{OP_NOP, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFFFFFF}, 1'b0, 32'd0}
  };

  // which register fields an opcode reads or writes
  function automatic void reg_fields(input logic [4:0] op, output bit ua, output bit ub,
                                     output bit ud);
    ua = 0; ub = 0; ud = 0;
    case (op)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR: begin
        ua = 1; ub = 1; ud = 1;
      end
      OP_STORE, OP_LOAD, OP_LDI, OP_PUSH, OP_POP, OP_JZ, OP_JNZ, OP_BZ, OP_BNZ: begin
        ua = 1;
      end
      OP_MOV, OP_JE, OP_JNE, OP_NOT, OP_CMP, OP_TEST, OP_NEG, OP_ABS: begin
        ua = 1; ub = 1;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // executes one instruction on the bench state and returns the outcome
  function automatic outcome_t execute_instr(input instr_t x);
    outcome_t   res;
    bit         ua, ub, ud, wr;
    logic [31:0] a, b, wv, q;
    logic [3:0] wreg;
    logic [15:0] np;
    wr = 0; wreg = '0; wv = '0;
    if (run_st == ST_RUN) begin
      reg_fields(x.op, ua, ub, ud);
      if (ip >= prog_len) begin
        run_st = ST_END;
      end else if (retired >= instr_limit) begin
        run_st = ST_LIMIT;
      end else if (x.op > OP_HALT) begin
        run_st = ST_UNKNOWN;
      end else if ((ua && x.ra >= REG_COUNT) || (ub && x.rb >= REG_COUNT) ||
                   (ud && x.rd >= REG_COUNT)) begin
        run_st = ST_BADREG;
      end else begin
        a = ua ? regs[x.ra[3:0]] : '0;
        b = ub ? regs[x.rb[3:0]] : '0;
        np = ip + 16'd1;
        case (x.op)
          OP_ADD: begin wr = 1; wreg = x.rd[3:0]; wv = a + b; end
          OP_SUB: begin wr = 1; wreg = x.rd[3:0]; wv = a - b; end
          OP_MUL: begin wr = 1; wreg = x.rd[3:0]; wv = a * b; end
          OP_DIV: begin
            if (b == 0) run_st = ST_DIVZERO;
            else begin
              q = abs32(a) / abs32(b);
              wr = 1; wreg = x.rd[3:0]; wv = (a[31] ^ b[31]) ? (32'd0 - q) : q;
            end
          end
          OP_STORE: begin
            if (x.addr >= MEM_WORDS) run_st = ST_BADADDR;
            else dmem[x.addr] = a;
          end
          OP_LOAD: begin
            if (x.addr >= MEM_WORDS) run_st = ST_BADADDR;
            else begin wr = 1; wreg = x.ra[3:0]; wv = dmem[x.addr]; end
          end
          OP_LDI: begin wr = 1; wreg = x.ra[3:0]; wv = x.imm; end
          OP_PUSH: begin
            if (sp_depth >= MEM_WORDS) run_st = ST_OVER;
            else begin dmem[MEM_WORDS - 1 - sp_depth] = a; sp_depth++; end
          end
          OP_POP: begin
            if (sp_depth == 0) run_st = ST_UNDER;
            else begin
              sp_depth--;
              wr = 1; wreg = x.ra[3:0]; wv = dmem[MEM_WORDS - 1 - sp_depth];
            end
          end
          OP_JMP, OP_B: np = x.addr;
          OP_JZ, OP_BZ: if (a == 0) np = x.addr;
          OP_JNZ, OP_BNZ: if (a != 0) np = x.addr;
          OP_MOV: begin wr = 1; wreg = x.ra[3:0]; wv = b; end
          OP_JE: if (a == b) np = x.addr;
          OP_JNE: if (a != b) np = x.addr;
          OP_AND: begin wr = 1; wreg = x.rd[3:0]; wv = a & b; end
          OP_OR: begin wr = 1; wreg = x.rd[3:0]; wv = a | b; end
          OP_XOR: begin wr = 1; wreg = x.rd[3:0]; wv = a ^ b; end
          OP_NOT: begin wr = 1; wreg = x.rb[3:0]; wv = ~a; end
          OP_SHL: begin wr = 1; wreg = x.rd[3:0]; wv = a << b[4:0]; end
          OP_SHR: begin wr = 1; wreg = x.rd[3:0]; wv = $signed(a) >>> b[4:0]; end
          OP_CMP: begin
            wr = 1; wreg = '0;
            wv = (a == b) ? 32'd0 : (($signed(a) < $signed(b)) ? 32'hFFFFFFFF : 32'd1);
          end
          OP_TEST: begin wr = 1; wreg = '0; wv = a & b; end
          OP_NEG: begin wr = 1; wreg = x.rb[3:0]; wv = 32'd0 - a; end
          OP_ABS: begin wr = 1; wreg = x.rb[3:0]; wv = abs32(a); end
          OP_HALT: begin run_st = ST_HALT; np = ip; end
          default: ;
        endcase
        if (run_st == ST_RUN || run_st == ST_HALT) begin
          if (wr) regs[wreg] = wv;
          retired++;
          ip = np;
        end else begin
          wr = 0;
        end
      end
    end
    if (!wr) begin wreg = '0; wv = '0; end
    res = '{ip, run_st, wr, wreg, wv};
    return res;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one request, predicting its outcome first
  task automatic issue(input instr_t x, input bit has_val = 0, input logic [31:0] val = '0);
    outcome_t res;
    int gap;
    res = execute_instr(x);
    if (has_val && res.wr) res.wval = val;
    pending_outcomes.push_back(res);
    gap = pick_gap(quiet_in);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    opcode_i = x.op; src_a_i = x.ra; src_b_i = x.rb; dest_reg_i = x.rd;
    address_i = x.addr; immediate_i = x.imm;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // keep the pointer inside the program
  task automatic keep_in_range();
    instr_t j;
    if (run_st == ST_RUN && ip >= prog_len - 2) begin
      j = '{OP_JMP, 8'($urandom), 8'($urandom), 8'($urandom),
            16'($urandom_range(0, prog_len - 2)), $urandom};
      issue(j);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFFFFFF;
      2: return 32'h80000000;
      3: return 32'h7FFFFFFF;
      4: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  // random instruction that keeps the run alive
  function automatic instr_t live_instr();
    instr_t x;
    bit ua, ub, ud;
    x = '{5'($urandom_range(0, 29)), 8'($urandom), 8'($urandom), 8'($urandom),
          16'($urandom), pick_value()};
    if (x.op == OP_HALT) x.op = OP_NOP;
    if (x.op == OP_PUSH && sp_depth >= MEM_WORDS) x.op = OP_POP;
    if (x.op == OP_POP && sp_depth == 0) x.op = OP_PUSH;
    reg_fields(x.op, ua, ub, ud);
    if (ua) x.ra = 8'($urandom_range(0, REG_COUNT - 1));
    if (ub) x.rb = 8'($urandom_range(0, REG_COUNT - 1));
    if (ud) x.rd = 8'($urandom_range(0, REG_COUNT - 1));
    if (x.op == OP_DIV && regs[x.rb[3:0]] == 0) x.op = OP_ADD;
    case (x.op)
      OP_STORE, OP_LOAD: x.addr = 16'($urandom_range(0, MEM_WORDS - 1));
      OP_JMP, OP_B, OP_JZ, OP_BZ, OP_JNZ, OP_BNZ, OP_JE, OP_JNE:
        x.addr = 16'($urandom_range(0, prog_len - 2));
      default: ;
    endcase
    return x;
  endfunction

  // wait for the block to drain before touching configuration
  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [7:0] idx, input logic [31:0] data);
    cfg_index_i = idx; cfg_data_i = data; cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    if (idx == CFG_PROGRAM_LENGTH) prog_len = data[15:0];
    else if (idx == CFG_INSTRUCTION_LIMIT) instr_limit = data;
  endtask

  // result checker
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        $display("[%0t] result with nothing expected", $realtime);
        mismatch_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (next_pointer_o !== want.ptr)
          report("next_pointer", 32'(next_pointer_o), 32'(want.ptr));
        if (status_o !== want.status) report("status", 32'(status_o), 32'(want.status));
        if (write_valid_o !== want.wr)
          report("write_valid", 32'(write_valid_o), 32'(want.wr));
        if (written_register_o !== want.wreg)
          report("written_register", 32'(written_register_o), 32'(want.wreg));
        if (written_value_o !== want.wval)
          report("written_value", written_value_o, want.wval);
      end
    end
  end

  // receiver stalls, with calm stretches
  always @(negedge clk_i) begin
    int hold;
    if (cycle_count % 300 == 0) begin
      quiet_out <= ($urandom_range(0, 3) == 0);
      quiet_in <= ($urandom_range(0, 3) == 0);
    end
    if (hold > 0) begin
      hold--;
    end else if (!quiet_out && $urandom_range(0, 99) < 30) begin
      hold = pick_gap(0);
    end
    out_stall_i <= (hold > 0);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int n;
    int kind;
    int phase_len;
    instr_t x;
    logic [15:0] lens [3];
    for (int i = 0; i < REG_COUNT; i++) regs[i] = '0;
    for (int i = 0; i < MEM_WORDS; i++) dmem[i] = '0;
    sp_depth = 0; ip = '0; retired = '0; run_st = ST_RUN;
    prog_len = '0; instr_limit = LIMIT_AT_RESET;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // widest settings, then the directed table
    write_cfg(CFG_PROGRAM_LENGTH, 32'd65535);
    write_cfg(CFG_INSTRUCTION_LIMIT, 32'hFFFFFFFF);
    for (int i = 0; i < ROWS; i++) begin
      issue(dir_rows[i].ins, dir_rows[i].known, dir_rows[i].wval);
    end

    // the closing stop event is picked first; filling the stack costs many requests
    kind = $urandom_range(0, 8);
    phase_len = (kind == 5) ? 90 : 420;

    // random phases under different program lengths
    lens[0] = 16'd65535;
    lens[1] = 16'($urandom_range(100, 65535));
    lens[2] = 16'd64;
    for (int p = 0; p < 3; p++) begin
      drain();
      if (ip >= lens[p] - 2) issue('{OP_JMP, 8'd0, 8'd0, 8'd0, 16'd0, 32'd0});
      drain();
      write_cfg(CFG_PROGRAM_LENGTH, 32'(lens[p]));
      if (p == 1) write_cfg(CFG_INSTRUCTION_LIMIT, retired + 32'd100000);
      for (int i = 0; i < phase_len; i++) begin
        keep_in_range();
        issue(live_instr());
      end
    end

    // one run-stopping event, then the stop must hold
    keep_in_range();
    case (kind)
      0: issue('{OP_HALT, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), $urandom});
      1: issue('{OP_ADD, 8'd1, 8'd2, 8'($urandom_range(REG_COUNT, 255)), 16'd0, 32'd0});
      2: issue('{OP_LOAD, 8'd3, 8'd0, 8'd0, 16'($urandom_range(MEM_WORDS, 65535)), 32'd0});
      3: begin
        n = $urandom_range(0, REG_COUNT - 1);
        issue('{OP_LDI, 8'(n), 8'd0, 8'd0, 16'd0, 32'd0});
        keep_in_range();
        issue('{OP_DIV, 8'd1, 8'(n), 8'd2, 16'd0, 32'd0});
      end
      4: begin
        while (sp_depth > 0) begin
          keep_in_range();
          issue('{OP_POP, 8'($urandom_range(0, REG_COUNT - 1)), 8'd0, 8'd0, 16'd0, 32'd0});
        end
        keep_in_range();
        issue('{OP_POP, 8'd5, 8'd0, 8'd0, 16'd0, 32'd0});
      end
      5: begin
        while (sp_depth < MEM_WORDS) begin
          keep_in_range();
          issue('{OP_PUSH, 8'($urandom_range(0, REG_COUNT - 1)), 8'd0, 8'd0, 16'd0, 32'd0});
        end
        keep_in_range();
        issue('{OP_PUSH, 8'd6, 8'd0, 8'd0, 16'd0, 32'd0});
      end
      6: issue('{5'($urandom_range(30, 31)), 8'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom), $urandom});
      7: begin
        drain();
        write_cfg(CFG_PROGRAM_LENGTH, $urandom_range(0, 1) ? 32'd0 : 32'(ip));
        issue(live_instr());
      end
      default: begin
        drain();
        write_cfg(CFG_INSTRUCTION_LIMIT, $urandom_range(0, 1) ? 32'd1 : retired);
        issue(live_instr());
      end
    endcase
    for (int i = 0; i < 12; i++) begin
      x = '{5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), $urandom};
      issue(x);
    end

    in_valid_i = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/rsme_pkg.sv
sv/register_stack_machine_executor.sv
bench/testbench.sv
